/* hdl/hata_pkg.sv */
// ----------------------------------------------------------------------------
// hata_pkg
// Types and fixed-point constants shared by the path loss pipeline.
// ----------------------------------------------------------------------------
package hata_pkg;

    // One link query.
    typedef struct packed {
        logic        big_city;
        logic [10:0] frequency_mhz;
        logic [10:0] base_height_dm;
        logic [6:0]  mobile_height_dm;
        logic [10:0] distance_dam;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [15:0] loss_db_q8;
        logic        range_clamped;
    } t_out_item;

    // Q16 constants.
    localparam logic signed [39:0] Q_69P55    = 40'sd4558029;
    localparam logic signed [39:0] Q_26P16    = 40'sd1714422;
    localparam logic signed [39:0] Q_13P82    = 40'sd905708;
    localparam logic signed [39:0] Q_44P9     = 40'sd2942566;
    localparam logic signed [39:0] Q_6P55     = 40'sd429261;
    localparam logic signed [39:0] Q_8P29     = 40'sd543293;
    localparam logic signed [39:0] Q_1P54_LG  = 40'sd12289;
    localparam logic signed [39:0] Q_11P75_LG = 40'sd70126;
    localparam logic signed [39:0] Q_1P1      = 40'sd72090;
    localparam logic signed [39:0] Q_3P2      = 40'sd209715;
    localparam logic signed [39:0] Q_4P97     = 40'sd325714;
    localparam logic signed [39:0] Q_1P56     = 40'sd102236;
    localparam logic signed [39:0] Q_0P8      = 40'sd52429;
    localparam logic signed [39:0] Q_0P7      = 40'sd45875;
    localparam logic signed [39:0] Q_ONE      = 40'sd65536;
    localparam logic [14:0]        Q_LG2      = 15'd19728;

    // Reciprocal of ten scaled by 2^27, rounded up; exact for the mobile
    // height conversion over its whole range.
    localparam logic [23:0] HM_RECIP = 24'd13421773;

    localparam logic [10:0] THR_RESET = 11'd200;

    // log2(1 + i/16) in Q16.
    function automatic logic [16:0] log2_tab(input logic [4:0] idx);
        logic [16:0] v;
        begin
            case (idx)
                5'd0:    v = 17'd0;
                5'd1:    v = 17'd5732;
                5'd2:    v = 17'd11136;
                5'd3:    v = 17'd16248;
                5'd4:    v = 17'd21098;
                5'd5:    v = 17'd25711;
                5'd6:    v = 17'd30109;
                5'd7:    v = 17'd34312;
                5'd8:    v = 17'd38336;
                5'd9:    v = 17'd42196;
                5'd10:   v = 17'd45904;
                5'd11:   v = 17'd49472;
                5'd12:   v = 17'd52911;
                5'd13:   v = 17'd56229;
                5'd14:   v = 17'd59434;
                5'd15:   v = 17'd62534;
                default: v = 17'd65536;
            endcase
            return v;
        end
    endfunction

    // Q16 product, floor toward minus infinity (arithmetic shift).
    // Every operand of the model stays well inside 32 signed bits.
    function automatic logic signed [39:0] qmul(input logic signed [39:0] a,
                                                input logic signed [39:0] b);
        logic signed [31:0] a_s;
        logic signed [31:0] b_s;
        logic signed [63:0] p;
        begin
            a_s = a[31:0];
            b_s = b[31:0];
            p   = a_s * b_s;
            return {{8{p[63]}}, p[47:16]};
        end
    endfunction

endpackage

/* hdl/hata_path_loss.sv */
// ----------------------------------------------------------------------------
// hata_path_loss
// Okumura-Hata median urban path loss, fixed-point pipeline.
// ----------------------------------------------------------------------------
// Usage: a query item enters on i_in_valid/i_in_data and is accepted when
// o_in_stall is low. One result item per query leaves on o_out_valid/
// o_out_data and is taken when i_out_stall is low.
// The pipeline has eight register stages; one item can be accepted every
// cycle unless the output stalls. Stage 1 clamps, stages 2-3 take the four
// logs, stages 4-5 evaluate the products of the model (one multiply deep
// each), stages 6-7 sum and stage 8 rounds and saturates into the output
// register.
// When the receiver stalls while the output register holds an item, the
// whole pipeline holds and o_in_stall rises, so nothing is lost or repeated.
// The user must write the frequency threshold register (i_cfg_we/i_cfg_data)
// only while the block is idle; the block does not enforce it. Synchronous
// reset clears all valid bits and sets the threshold to 200 MHz.
// ----------------------------------------------------------------------------
module hata_path_loss #(
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [10:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hata_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hata_pkg::t_out_item  o_out_data
);

    localparam int NST   = 8;
    localparam int SHIFT = 16 - OUT_FRAC_BITS;
    localparam logic signed [39:0] HALF =
        (SHIFT > 0) ? 40'sd1 <<< (SHIFT > 0 ? SHIFT - 1 : 0) : 40'sd0;

    logic [10:0]    r_thr;
    logic [NST-1:0] r_vld;
    logic           adv;

    // The pipeline moves whenever the last stage is empty or being taken.
    assign adv         = !(r_vld[NST-1] && i_out_stall);
    assign o_in_stall  = !adv;
    assign o_out_valid = r_vld[NST-1];

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= hata_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // Stage 1: clamp.
    logic [10:0] n_f, n_hb, n_d;
    logic [6:0]  n_hm;
    logic        n_hit;
    logic [10:0] r1_f, r1_hb, r1_d;
    logic [6:0]  r1_hm;
    logic        r1_hit, r1_lc;

    always_comb begin
        n_hit = 1'b0;
        n_f   = i_in_data.frequency_mhz;
        if (n_f < 11'd150) begin n_f = 11'd150; n_hit = 1'b1; end
        if (n_f > 11'd1500) begin n_f = 11'd1500; n_hit = 1'b1; end
        n_hb = i_in_data.base_height_dm;
        if (n_hb < 11'd300) begin n_hb = 11'd300; n_hit = 1'b1; end
        if (n_hb > 11'd2000) begin n_hb = 11'd2000; n_hit = 1'b1; end
        n_hm = i_in_data.mobile_height_dm;
        if (n_hm < 7'd10) begin n_hm = 7'd10; n_hit = 1'b1; end
        if (n_hm > 7'd100) begin n_hm = 7'd100; n_hit = 1'b1; end
        n_d = i_in_data.distance_dam;
        if (n_d < 11'd100) begin n_d = 11'd100; n_hit = 1'b1; end
        if (n_d > 11'd2000) begin n_d = 11'd2000; n_hit = 1'b1; end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_f   <= n_f;
            r1_hb  <= n_hb;
            r1_hm  <= n_hm;
            r1_d   <= n_d;
            r1_hit <= n_hit;
            r1_lc  <= i_in_data.big_city;
        end
    end

    // Stages 2-3: logs, with side data carried along.
    logic signed [39:0] lg_f, lg_hb, lg_hm, lg_d;

    hata_log u_log_f  (.i_clk(i_clk), .i_en(adv), .i_x(r1_f),  .o_lg(lg_f));
    hata_log u_log_hb (.i_clk(i_clk), .i_en(adv), .i_x(r1_hb), .o_lg(lg_hb));
    hata_log u_log_hm (.i_clk(i_clk), .i_en(adv), .i_x({4'd0, r1_hm}), .o_lg(lg_hm));
    hata_log u_log_d  (.i_clk(i_clk), .i_en(adv), .i_x(r1_d),  .o_lg(lg_d));

    logic [6:0] r2_hm, r3_hm;
    logic       r2_hit, r3_hit, r2_lc, r3_lc, r2_low, r3_low;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_hm  <= r1_hm;
            r2_hit <= r1_hit;
            r2_lc  <= r1_lc;
            r2_low <= (r1_f <= r_thr);
            r3_hm  <= r2_hm;
            r3_hit <= r2_hit;
            r3_lc  <= r2_lc;
            r3_low <= r2_low;
        end
    end

    // Stage 4: first products.
    logic signed [39:0] lhb, lhm, ld, tm, hm_m;
    logic [46:0]        hm_p;
    logic signed [39:0] r4_p26, r4_p13, r4_p655, r4_p11, r4_p156, r4_tt, r4_ld, r4_hm;
    logic               r4_hit, r4_lc, r4_low;

    always_comb begin
        lhb  = lg_hb - hata_pkg::Q_ONE;
        lhm  = lg_hm - hata_pkg::Q_ONE;
        ld   = lg_d - (hata_pkg::Q_ONE <<< 1);
        tm   = lhm + (r3_low ? hata_pkg::Q_1P54_LG : hata_pkg::Q_11P75_LG);
        // Height in meters: (hm * 65536 + 5) / 10 by reciprocal multiply.
        hm_p = {24'd0, r3_hm, 16'd5} * {23'd0, hata_pkg::HM_RECIP};
        hm_m = 40'(hm_p >> 27);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_p26  <= hata_pkg::qmul(hata_pkg::Q_26P16, lg_f);
            r4_p13  <= hata_pkg::qmul(hata_pkg::Q_13P82, lhb);
            r4_p655 <= hata_pkg::qmul(hata_pkg::Q_6P55, lhb);
            r4_p11  <= hata_pkg::qmul(hata_pkg::Q_1P1, lg_f);
            r4_p156 <= hata_pkg::qmul(hata_pkg::Q_1P56, lg_f);
            r4_tt   <= hata_pkg::qmul(tm, tm);
            r4_ld   <= ld;
            r4_hm   <= hm_m;
            r4_hit  <= r3_hit;
            r4_lc   <= r3_lc;
            r4_low  <= r3_low;
        end
    end

    // Stage 5: second products.
    logic signed [39:0] r5_base, r5_dist, r5_a;
    logic               r5_hit;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_base <= hata_pkg::Q_69P55 + r4_p26 - r4_p13;
            r5_dist <= hata_pkg::qmul(hata_pkg::Q_44P9 - r4_p655, r4_ld);
            if (r4_lc) begin
                if (r4_low) begin
                    r5_a <= hata_pkg::qmul(hata_pkg::Q_8P29, r4_tt) - hata_pkg::Q_1P1;
                end else begin
                    r5_a <= hata_pkg::qmul(hata_pkg::Q_3P2, r4_tt) - hata_pkg::Q_4P97;
                end
            end else begin
                r5_a <= hata_pkg::qmul(r4_p11 - hata_pkg::Q_0P7, r4_hm)
                      - (r4_p156 - hata_pkg::Q_0P8);
            end
            r5_hit <= r4_hit;
        end
    end

    // Stage 6: partial sum.
    logic signed [39:0] r6_s;
    logic signed [39:0] r6_a;
    logic               r6_hit;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_s   <= r5_base + r5_dist;
            r6_a   <= r5_a;
            r6_hit <= r5_hit;
        end
    end

    // Stage 7: loss.
    logic signed [39:0] r7_loss;
    logic               r7_hit;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_loss <= r6_s - r6_a;
            r7_hit  <= r6_hit;
        end
    end

    // Stage 8: round, clip and saturate.
    logic signed [39:0] rnd;
    logic [15:0]        n_res;

    always_comb begin
        rnd = (r7_loss + HALF) >>> SHIFT;
        if (r7_loss <= 40'sd0) begin
            n_res = 16'd0;
        end else if (rnd > 40'sd65535) begin
            n_res = 16'hFFFF;
        end else begin
            n_res = rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_data.loss_db_q8    <= n_res;
            o_out_data.range_clamped <= r7_hit;
        end
    end

endmodule

/* hdl/hata_log.sv */
// ----------------------------------------------------------------------------
// hata_log
// Two-stage base-10 log of an 11-bit integer, Q16 result.
// ----------------------------------------------------------------------------
module hata_log (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [10:0]        i_x,
    output logic signed [39:0] o_lg
);

    logic [3:0]  n;
    logic [26:0] m;
    logic [15:0] r;
    logic [3:0]  ti;
    logic [11:0] tf;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [29:0] n_l2;
    logic [29:0] r_l2;
    logic [44:0] prod;

    // Leading-one position, normalize and interpolate.
    always_comb begin
        n = 4'd0;
        for (int k = 1; k < 11; k++) begin
            if (i_x[k]) n = 4'(k);
        end
        m    = {i_x, 16'd0} >> n;
        r    = m[15:0];
        ti   = r[15:12];
        tf   = r[11:0];
        t0   = hata_pkg::log2_tab({1'b0, ti});
        t1   = hata_pkg::log2_tab({1'b0, ti} + 5'd1);
        n_l2 = {10'd0, n, 16'd0} + {13'd0, t0}
             + 30'(({17'd0, (t1 - t0)} * {22'd0, tf}) >> 12);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l2 <= n_l2;
        end
    end

    // Scale by lg 2.
    assign prod = {15'd0, r_l2} * {30'd0, hata_pkg::Q_LG2};
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lg <= 40'(prod >> 16);
        end
    end

endmodule
